// ===== src/uml_pkg.sv =====
package uml_pkg;

   localparam int SAMPLE_COUNT = 5;
   localparam int ECHO_BITS    = 15;

   localparam int DEPTH_BITS     = 15;
   localparam int LEVEL_BITS     = 14;
   localparam int MEDIAN_BITS    = 15;
   localparam int COUNT_OUT_BITS = 3;

   localparam int CNT_BITS = $clog2(SAMPLE_COUNT + 1);
   localparam int IDX_BITS = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int CMP_BITS = (ECHO_BITS > DEPTH_BITS) ? ECHO_BITS : DEPTH_BITS;

   localparam int NUM_BITS     = LEVEL_BITS + DEPTH_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_BIN_DEPTH = '0;

   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET      = 15'd1749;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL_SCALE = 14'd10000;

   typedef logic [ECHO_BITS-1:0]  echo_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;
   typedef logic [LEVEL_BITS-1:0] level_type;

   // one finished burst handed from the front to the back
   typedef struct packed {
      logic [SAMPLE_COUNT-1:0][ECHO_BITS-1:0] samples;
      cnt_type                                count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      level_type                level_centi_pct;
      logic [MEDIAN_BITS-1:0]   median_echo_us;
      logic [COUNT_OUT_BITS-1:0] valid_count;
      logic                     held;
   } result_type;

endpackage

// ===== src/uml_front.sv =====
module uml_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [uml_pkg::ECHO_BITS-1:0] req_echo_us,
   output logic                     req_stall,
   input  uml_pkg::queue_status_type queue_status,
   output logic                     push,
   output uml_pkg::job_type         push_job
);
   import uml_pkg::*;

   echo_type store_ff [SAMPLE_COUNT];
   cnt_type  valid_cnt_ff, valid_cnt_in;
   cnt_type  position_ff, position_in;

   logic accept;
   logic keep;
   logic burst_end;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign keep      = (req_echo_us != '0) && (valid_cnt_ff < CNT_BITS'(SAMPLE_COUNT));
   assign burst_end = (position_ff == CNT_BITS'(SAMPLE_COUNT - 1));
   assign push      = accept && burst_end;

   always_comb begin
      valid_cnt_in = valid_cnt_ff;
      position_in  = position_ff;
      if (accept) begin
         if (burst_end) begin
            valid_cnt_in = '0;
            position_in  = '0;
         end else begin
            position_in = position_ff + 1'b1;
            if (keep) valid_cnt_in = valid_cnt_ff + 1'b1;
         end
      end
   end

   // fold the request of this cycle into the burst being pushed
   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         push_job.samples[i] = store_ff[i];
      end
      if (keep) push_job.samples[valid_cnt_ff[IDX_BITS-1:0]] = req_echo_us;
      push_job.count = keep ? valid_cnt_ff + 1'b1 : valid_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_cnt_ff <= '0;
         position_ff  <= '0;
      end else begin
         valid_cnt_ff <= valid_cnt_in;
         position_ff  <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) store_ff[valid_cnt_ff[IDX_BITS-1:0]] <= req_echo_us;
   end

endmodule

// ===== src/uml_job_queue.sv =====
module uml_job_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  uml_pkg::job_type          push_job,
   input  logic                      pop,
   output uml_pkg::job_type          pop_job,
   output uml_pkg::queue_status_type status
);
   import uml_pkg::*;

   job_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_FILL_BITS-1:0] fill_ff, fill_in;
   logic                       do_push, do_pop;

   assign status.full  = (fill_ff == QUEUE_FILL_BITS'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = entries_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== src/uml_back.sv =====
module uml_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [uml_pkg::DEPTH_BITS-1:0] bin_depth,
   input  uml_pkg::queue_status_type queue_status,
   input  uml_pkg::job_type          pop_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output uml_pkg::result_type       result
);
   import uml_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SELECT = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff;
   logic [IDX_BITS-1:0]     idx_ff;
   echo_type                median_ff;
   logic [NUM_BITS-1:0]     num_ff;
   depth_type               rem_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   level_type               held_level_ff;
   logic                    rsp_valid_ff;
   result_type              result_ff;

   echo_type               cand;
   cnt_type                lt_cnt, le_cnt, rank;
   logic                   hit;
   logic [CMP_BITS-1:0]    med_wide, depth_wide;
   logic                   over_depth;
   depth_type              diff;
   logic [DEPTH_BITS:0]    rem_shift;
   logic                   rem_ge;
   level_type              level;

   assign pop = (state_ff == ST_IDLE) && !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // rank of the current candidate among the kept samples
   always_comb begin
      cand   = job_ff.samples[idx_ff];
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
         if (CNT_BITS'(j) < job_ff.count) begin
            if (job_ff.samples[j] < cand) lt_cnt = lt_cnt + 1'b1;
            if (job_ff.samples[j] <= cand) le_cnt = le_cnt + 1'b1;
         end
      end
      rank = job_ff.count >> 1;
      hit  = (CNT_BITS'(idx_ff) < job_ff.count) && (lt_cnt <= rank) && (rank < le_cnt);
   end

   assign med_wide   = CMP_BITS'(median_ff);
   assign depth_wide = CMP_BITS'(bin_depth);
   assign over_depth = (med_wide >= depth_wide) || (bin_depth == '0);
   assign diff       = DEPTH_BITS'(depth_wide - med_wide);
   assign rem_shift  = {rem_ff, num_ff[NUM_BITS-1]};
   assign rem_ge     = rem_shift >= {1'b0, bin_depth};
   assign level      = LEVEL_BITS'(num_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (pop) state_in = (pop_job.count == '0) ? ST_DONE : ST_SELECT;
         ST_SELECT: if (hit || idx_ff == IDX_BITS'(SAMPLE_COUNT - 1)) state_in = ST_MULT;
         ST_MULT:   state_in = over_depth ? ST_DONE : ST_DIVIDE;
         ST_DIVIDE: if (div_cnt_ff == '0) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_level_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
            if (job_ff.count != '0) held_level_ff <= level;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            job_ff    <= pop_job;
            idx_ff    <= '0;
            median_ff <= '0;
         end
         ST_SELECT: begin
            if (hit) median_ff <= cand;
            idx_ff <= idx_ff + 1'b1;
         end
         ST_MULT: begin
            num_ff     <= over_depth ? '0 : NUM_BITS'(diff) * NUM_BITS'(LEVEL_FULL_SCALE);
            rem_ff     <= '0;
            div_cnt_ff <= DIV_CNT_BITS'(NUM_BITS - 1);
         end
         ST_DIVIDE: begin
            // restoring step: quotient bits shift in from the bottom
            if (rem_ge) begin
               rem_ff <= DEPTH_BITS'(rem_shift - {1'b0, bin_depth});
               num_ff <= {num_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift[DEPTH_BITS-1:0];
               num_ff <= {num_ff[NUM_BITS-2:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         ST_DONE: begin
            result_ff.median_echo_us <= MEDIAN_BITS'(median_ff);
            result_ff.valid_count    <= COUNT_OUT_BITS'(job_ff.count);
            if (job_ff.count == '0) begin
               result_ff.level_centi_pct <= held_level_ff;
               result_ff.held            <= 1'b1;
            end else begin
               result_ff.level_centi_pct <= level;
               result_ff.held            <= 1'b0;
            end
         end
         default: begin
            idx_ff <= '0;
         end
      endcase
   end

endmodule

// ===== src/ultrasonic_median_level.sv =====
// Flow: with the back end free and no output stall, the last request of a burst yields
//   its result through
//   queue pop, up to 5 median selection steps, a multiply, up to 29 divide steps and a write-out;
//   an empty burst goes from queue pop straight to write-out.
// Throughput: one request per cycle while the 2-deep burst queue has room; the back end
//   works on one burst at a time with a bit-serial divider and pops the next only when idle.
// Reset: synchronous; clears counters, queue, held level and output valid; depth reg = 1749.
module ultrasonic_median_level (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [uml_pkg::ECHO_BITS-1:0]     req_echo_us,
   output logic                              req_stall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [uml_pkg::LEVEL_BITS-1:0]    rsp_level_centi_pct,
   output logic [uml_pkg::MEDIAN_BITS-1:0]   rsp_median_echo_us,
   output logic [uml_pkg::COUNT_OUT_BITS-1:0] rsp_valid_count,
   output logic                              rsp_held,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [uml_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [uml_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [uml_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import uml_pkg::*;

   depth_type        depth_ff;
   logic [CSR_IDX_BITS-1:0] csr_index;
   queue_status_type queue_status;
   logic             push, pop;
   job_type          push_job, pop_job;
   result_type       result;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_prdata = (csr_index == REG_BIN_DEPTH) ? CSR_DATA_BITS'(depth_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_index == REG_BIN_DEPTH) begin
         depth_ff <= csr_pwdata[DEPTH_BITS-1:0];
      end
   end

   uml_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_echo_us  (req_echo_us),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   uml_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (queue_status)
   );

   uml_back u_back (
      .clock        (clock),
      .reset        (reset),
      .bin_depth    (depth_ff),
      .queue_status (queue_status),
      .pop_job      (pop_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .result       (result)
   );

   assign rsp_level_centi_pct = result.level_centi_pct;
   assign rsp_median_echo_us  = result.median_echo_us;
   assign rsp_valid_count     = result.valid_count;
   assign rsp_held            = result.held;

`ifndef SYNTHESIS
   a_held_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held |-> rsp_valid_count == '0 && rsp_median_echo_us == '0)
      else $error("held result carries samples");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_held |-> rsp_level_centi_pct <= LEVEL_FULL_SCALE)
      else $error("level beyond full scale");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
